// ===== hdl/crce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_pkg
// types, codes and card image helpers shared by the card reader engine
// ----------------------------------------------------------------------------
package crce_pkg;

    // card store geometry (positions wrap at the card size)
    localparam int CARD_SIZE = 512;
    localparam int CARD_AW   = $clog2(CARD_SIZE);

    localparam logic [CARD_AW-1:0] BALANCE_POS = CARD_AW'(8);
    localparam logic [CARD_AW-1:0] MAGIC_POS   = CARD_AW'(0);
    localparam logic [CARD_AW-1:0] VERSION_POS = CARD_AW'(4);

    // item modes
    localparam logic [2:0] MODE_REG_WRITE = 3'd0;
    localparam logic [2:0] MODE_REG_READ  = 3'd1;
    localparam logic [2:0] MODE_DMA_READ  = 3'd2;
    localparam logic [2:0] MODE_DMA_WRITE = 3'd3;
    localparam logic [2:0] MODE_INSERT    = 3'd4;
    localparam logic [2:0] MODE_EJECT     = 3'd5;

    // register selects
    localparam logic [1:0] SEL_STATUS  = 2'd0;
    localparam logic [1:0] SEL_COMMAND = 2'd1;
    localparam logic [1:0] SEL_OTHER   = 2'd2;

    // command opcodes (top byte of a command write)
    localparam logic [7:0] OPC_READ   = 8'hA5;
    localparam logic [7:0] OPC_PREP   = 8'hB4;
    localparam logic [7:0] OPC_STAT   = 8'hD2;
    localparam logic [7:0] OPC_IDENT  = 8'hE1;
    localparam logic [7:0] OPC_COMMIT = 8'hF0;
    localparam logic [31:0] ARG_MASK  = 32'h00FF_FFFF;

    // status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOCARD = 2'd1;
    localparam logic [1:0] STAT_READY  = 2'd2;

    // pending transfer codes
    localparam logic [2:0] PD_IDLE   = 3'd0;
    localparam logic [2:0] PD_ID     = 3'd1;
    localparam logic [2:0] PD_BLOCK  = 3'd2;
    localparam logic [2:0] PD_COMMIT = 3'd3;
    localparam logic [2:0] PD_READ   = 3'd4;

    // configuration register indexes
    localparam logic CFG_DEVICE_IDENT    = 1'b0;
    localparam logic CFG_INITIAL_BALANCE = 1'b1;

    // magic bytes
    localparam logic [31:0] MAGIC_WORD = {8'h50, 8'h4F, 8'h4B, 8'h45};

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  register_select;
        logic [31:0] write_value;
        logic [11:0] beat_index;
        logic [12:0] transfer_size;
        logic        last_beat;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [7:0]  dma_byte;
        logic [1:0]  status_code;
        logic        card_present;
        logic [31:0] card_balance;
        logic [2:0]  pending_state;
    } t_out_item;

    // read request into the card store
    typedef struct packed {
        logic               rd_en;
        logic [CARD_AW-1:0] rd_addr;
    } t_store_req;

    // byte of the card image after reset, without the balance bytes
    function automatic logic [7:0] f_base_byte(input logic [CARD_AW-1:0] addr);
        logic [CARD_AW-1:0] d_mag;
        logic [CARD_AW-1:0] d_ver;
        logic [7:0]         b;
        d_mag = addr - MAGIC_POS;
        d_ver = addr - VERSION_POS;
        b     = 8'h00;
        // version bytes land after the magic ones
        if (d_ver == CARD_AW'(0)) begin
            b = 8'h00;
        end else if (d_ver == CARD_AW'(1)) begin
            b = 8'h01;
        end else if (d_mag < CARD_AW'(4)) begin
            b = MAGIC_WORD[8*(3-int'(d_mag[1:0])) +: 8];
        end
        return b;
    endfunction

endpackage

// ===== hdl/crce_card_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_card_store
// card image memory with a fill pass after reset and one registered read port
// ----------------------------------------------------------------------------
module crce_card_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crce_pkg::t_store_req  i_req,
    output logic [7:0]            o_rd_data,
    output logic                  o_busy
);
    import crce_pkg::*;

    typedef enum logic [1:0] {
        SS_FILL = 2'b01,
        SS_RUN  = 2'b10
    } t_store_state;

    logic [7:0]         r_mem [CARD_SIZE];
    logic [7:0]         r_rd_data;
    t_store_state       r_state;
    logic [CARD_AW-1:0] r_fill_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SS_FILL;
            r_fill_addr <= '0;
        end else begin
            case (r_state)
                SS_FILL: begin
                    r_fill_addr <= r_fill_addr + CARD_AW'(1);
                    if (r_fill_addr == CARD_AW'(CARD_SIZE - 1)) begin
                        r_state <= SS_RUN;
                    end
                end
                SS_RUN: begin
                    r_state <= SS_RUN;
                end
                default: begin
                    r_state <= SS_FILL;
                end
            endcase
        end
    end

    // write port: fill pass only
    always_ff @(posedge i_clk) begin
        if (r_state == SS_FILL) begin
            r_mem[r_fill_addr] <= f_base_byte(r_fill_addr);
        end
    end

    // read port, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = (r_state != SS_RUN);

endmodule

// ===== hdl/card_reader_command_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_reader_command_engine_top
// credit card reader peripheral: register, dma and card event transactions
// ----------------------------------------------------------------------------
// usage
//   input channel: one transaction per item (register write, status read,
//   dma read beat, dma write, card insert, card eject) on i_in_valid /
//   o_in_stall with payload i_in_data
//   output channel: exactly one result per item on o_out_valid / i_out_stall,
//   reporting read data, the dma byte and the state after the item
//   config channel: i_cfg_valid / o_cfg_ready, always ready; index 0 is the
//   device identifier, index 1 the initial balance (also loads the balance)
//   results pass the middle stage and then the result register; one item
//   per cycle without stalls, set by the single read port of the card store
//   the receiver stalling holds the result register and then the middle
//   stage; the input stalls only once both are full
//   after reset the card store runs a fill pass writing the whole card
//   image; o_in_stall is high for that time, config writes still land
// ----------------------------------------------------------------------------
module card_reader_command_engine_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  crce_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output crce_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import crce_pkg::*;

    // middle stage: everything but the card byte, which arrives from memory
    typedef struct packed {
        t_out_item  item;
        logic       card_sel;
        logic       ovl_hit;
        logic [7:0] ovl_byte;
    } t_s1;

    // architectural state
    logic [31:0] r_device_ident;
    logic [31:0] r_balance;
    logic [2:0]  r_pending;
    logic [1:0]  r_status;
    logic        r_inserted;
    logic [23:0] r_read_offset;

    logic [31:0] n_balance;
    logic [2:0]  n_pending;
    logic [1:0]  n_status;
    logic        n_inserted;
    logic [23:0] n_read_offset;

    // pipeline
    logic      r_s1_valid;
    t_s1       r_s1;
    t_s1       n_s1;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic               s0_acc;
    logic               s1_move;
    logic               cfg_we;
    logic               store_busy;
    logic [7:0]         store_data;
    t_store_req         store_req;
    logic [CARD_AW-1:0] card_addr;
    logic [CARD_AW-1:0] bal_diff;
    logic [31:0]        read_data;
    logic [7:0]         id_byte;
    logic               card_sel;

    // handshakes
    assign s1_move     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = store_busy || (r_s1_valid && !s1_move);
    assign s0_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // card byte address wraps at the card size
    assign card_addr = r_read_offset[CARD_AW-1:0] + i_in_data.beat_index[CARD_AW-1:0];
    assign bal_diff  = card_addr - BALANCE_POS;

    assign store_req.rd_en   = s0_acc;
    assign store_req.rd_addr = card_addr;

    crce_card_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (store_data),
        .o_busy    (store_busy)
    );

    // next state and result of the item at the input
    always_comb begin
        n_balance     = r_balance;
        n_pending     = r_pending;
        n_status      = r_status;
        n_inserted    = r_inserted;
        n_read_offset = r_read_offset;
        read_data     = '0;
        id_byte       = '0;
        card_sel      = 1'b0;

        case (i_in_data.mode)
            MODE_REG_WRITE: begin
                if (i_in_data.register_select == SEL_STATUS) begin
                    // only a zero write clears, anything else is dropped
                    if (i_in_data.write_value == '0) begin
                        n_pending = PD_IDLE;
                        n_status  = r_inserted ? STAT_OK : STAT_NOCARD;
                    end
                end else if (i_in_data.register_select == SEL_COMMAND) begin
                    case (i_in_data.write_value[31:24])
                        OPC_STAT: begin
                            n_status = r_inserted ? STAT_OK : STAT_NOCARD;
                        end
                        OPC_IDENT: begin
                            n_pending = PD_ID;
                            n_status  = STAT_OK;
                        end
                        OPC_READ: begin
                            n_read_offset = i_in_data.write_value[23:0] & ARG_MASK[23:0];
                            n_pending     = PD_READ;
                            n_status      = STAT_READY;
                        end
                        OPC_PREP: begin
                            n_pending = PD_BLOCK;
                            n_status  = STAT_OK;
                        end
                        OPC_COMMIT: begin
                            n_pending = PD_COMMIT;
                            n_status  = STAT_OK;
                        end
                        default: begin
                            n_pending = r_pending;
                        end
                    endcase
                end
            end
            MODE_REG_READ: begin
                if (i_in_data.register_select == SEL_STATUS) begin
                    read_data = {30'd0, r_status};
                end
            end
            MODE_DMA_READ: begin
                if (i_in_data.transfer_size != '0) begin
                    if (r_pending == PD_ID) begin
                        // identifier big-endian on beats four to seven
                        if (i_in_data.transfer_size >= 13'd8
                                && i_in_data.beat_index >= 12'd4
                                && i_in_data.beat_index < 12'd8) begin
                            case (i_in_data.beat_index[1:0])
                                2'd0:    id_byte = r_device_ident[31:24];
                                2'd1:    id_byte = r_device_ident[23:16];
                                2'd2:    id_byte = r_device_ident[15:8];
                                default: id_byte = r_device_ident[7:0];
                            endcase
                        end
                        if (i_in_data.last_beat) begin
                            n_pending = PD_IDLE;
                        end
                    end else if (r_pending == PD_READ) begin
                        card_sel = r_inserted;
                        if (i_in_data.last_beat) begin
                            n_pending = PD_IDLE;
                        end
                    end
                end
            end
            MODE_DMA_WRITE: begin
                if (i_in_data.transfer_size != '0) begin
                    if (r_pending == PD_BLOCK) begin
                        n_pending = PD_IDLE;
                        n_status  = STAT_OK;
                    end else if (r_pending == PD_COMMIT) begin
                        if (r_inserted && r_balance != '0) begin
                            n_balance = r_balance - 32'd1;
                        end
                        n_pending = PD_IDLE;
                        n_status  = STAT_OK;
                    end
                end
            end
            MODE_INSERT: begin
                n_inserted = 1'b1;
                n_status   = STAT_OK;
            end
            MODE_EJECT: begin
                n_inserted = 1'b0;
                n_status   = STAT_NOCARD;
            end
            default: begin
                n_status = r_status;
            end
        endcase

        n_s1.item.read_data     = read_data;
        n_s1.item.dma_byte      = id_byte;
        n_s1.item.status_code   = n_status;
        n_s1.item.card_present  = n_inserted;
        n_s1.item.card_balance  = n_balance;
        n_s1.item.pending_state = n_pending;
        n_s1.card_sel           = card_sel;
        // balance bytes are forwarded from the balance register over the image
        n_s1.ovl_hit            = (bal_diff < CARD_AW'(4));
        n_s1.ovl_byte           = r_balance[8*(3-int'(bal_diff[1:0])) +: 8];
    end

    // result of the middle stage, card byte merged in from the store
    always_comb begin
        n_out = r_s1.item;
        if (r_s1.card_sel) begin
            n_out.dma_byte = r_s1.ovl_hit ? r_s1.ovl_byte : store_data;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_ident <= '0;
            r_balance      <= '0;
            r_pending      <= PD_IDLE;
            r_status       <= STAT_NOCARD;
            r_inserted     <= 1'b0;
            r_read_offset  <= '0;
        end else begin
            if (cfg_we && i_cfg_index == CFG_DEVICE_IDENT) begin
                r_device_ident <= i_cfg_data;
            end
            if (cfg_we && i_cfg_index == CFG_INITIAL_BALANCE) begin
                r_balance <= i_cfg_data;
            end else if (s0_acc) begin
                r_balance <= n_balance;
            end
            if (s0_acc) begin
                r_pending     <= n_pending;
                r_status      <= n_status;
                r_inserted    <= n_inserted;
                r_read_offset <= n_read_offset;
            end
        end
    end

    // middle stage and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_s1_valid || s1_move) begin
                r_s1_valid <= s0_acc;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_acc) begin
            r_s1 <= n_s1;
        end
        if (r_s1_valid && s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // nothing enters while the card image is being filled
    a_no_accept_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_busy |-> !s0_acc)
        else $error("item accepted during card store fill");

    // pending code stays within the defined transfers
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pending_state <= PD_READ
                         && o_out_data.status_code <= STAT_READY))
        else $error("result carries an undefined pending or status code");

    // without a config write the balance only ever drops by one
    a_balance_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_we |=> (r_balance == $past(r_balance)
                     || r_balance == $past(r_balance) - 32'd1))
        else $error("balance moved by more than one credit");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the card reader command engine: directed and
// random register, dma and card transactions, every reply compared field by
// field against a cycle-free mirror of the engine kept in a small scoreboard
// ----------------------------------------------------------------------------

module tb_top;
    import crce_pkg::*;

    // mirror of the engine state plus the queue of replies still owed
    class reply_scoreboard;
        logic [31:0] m_ident;
        logic [2:0]  m_pending;
        logic [1:0]  m_status;
        logic        m_inserted;
        logic [23:0] m_offset;
        logic [31:0] m_balance;
        logic [7:0]  m_card [CARD_SIZE];

        t_out_item   awaited_replies [$];
        int          n_errors;
        int          n_checked;
        int          n_card_bytes;
        int          n_credits;

        function new();
            m_ident    = '0;
            m_pending  = PD_IDLE;
            m_status   = STAT_NOCARD;
            m_inserted = 1'b0;
            m_offset   = '0;
            foreach (m_card[i]) m_card[i] = 8'h00;
            for (int i = 0; i < 4; i++) begin
                m_card[CARD_AW'(MAGIC_POS + i)] = MAGIC_WORD[8*(3-i) +: 8];
            end
            m_card[CARD_AW'(VERSION_POS)]     = 8'h00;
            m_card[CARD_AW'(VERSION_POS + 1)] = 8'h01;
            put_balance(32'h0);
            n_errors     = 0;
            n_checked    = 0;
            n_card_bytes = 0;
            n_credits    = 0;
        endfunction

        // balance lives in a register and big-endian in the card image
        function void put_balance(logic [31:0] b);
            m_balance = b;
            for (int i = 0; i < 4; i++) begin
                m_card[CARD_AW'(BALANCE_POS + i)] = b[8*(3-i) +: 8];
            end
        endfunction

        function void write_register(logic idx, logic [31:0] value);
            if (idx == CFG_DEVICE_IDENT) begin
                m_ident = value;
            end else begin
                put_balance(value);
            end
        endfunction

        // runs one accepted transaction through the mirror, returns its reply
        function t_out_item mirror_item(t_in_item it);
            t_out_item          r;
            logic [CARD_AW-1:0] addr;
            r = '0;
            case (it.mode)
                MODE_REG_WRITE: begin
                    if (it.register_select == SEL_STATUS) begin
                        if (it.write_value == 32'h0) begin
                            m_pending = PD_IDLE;
                            m_status  = m_inserted ? STAT_OK : STAT_NOCARD;
                        end
                    end else if (it.register_select == SEL_COMMAND) begin
                        case (it.write_value[31:24])
                            OPC_STAT: begin
                                m_status = m_inserted ? STAT_OK : STAT_NOCARD;
                            end
                            OPC_IDENT: begin
                                m_pending = PD_ID;
                                m_status  = STAT_OK;
                            end
                            OPC_READ: begin
                                m_offset  = it.write_value[23:0];
                                m_pending = PD_READ;
                                m_status  = STAT_READY;
                            end
                            OPC_PREP: begin
                                m_pending = PD_BLOCK;
                                m_status  = STAT_OK;
                            end
                            OPC_COMMIT: begin
                                m_pending = PD_COMMIT;
                                m_status  = STAT_OK;
                            end
                            default: ;
                        endcase
                    end
                end
                MODE_REG_READ: begin
                    if (it.register_select == SEL_STATUS) r.read_data = {30'h0, m_status};
                end
                MODE_DMA_READ: begin
                    if (it.transfer_size != 13'h0) begin
                        if (m_pending == PD_ID) begin
                            if (it.transfer_size >= 13'd8 && it.beat_index >= 12'd4 &&
                                it.beat_index < 12'd8) begin
                                r.dma_byte = m_ident[8*(7 - int'(it.beat_index)) +: 8];
                            end
                            if (it.last_beat) m_pending = PD_IDLE;
                        end else if (m_pending == PD_READ) begin
                            if (m_inserted) begin
                                addr = m_offset[CARD_AW-1:0] + it.beat_index[CARD_AW-1:0];
                                r.dma_byte = m_card[addr];
                                n_card_bytes++;
                            end
                            if (it.last_beat) m_pending = PD_IDLE;
                        end
                    end
                end
                MODE_DMA_WRITE: begin
                    if (it.transfer_size != 13'h0) begin
                        if (m_pending == PD_BLOCK) begin
                            m_pending = PD_IDLE;
                            m_status  = STAT_OK;
                        end else if (m_pending == PD_COMMIT) begin
                            if (m_inserted && m_balance != 32'h0) begin
                                put_balance(m_balance - 32'h1);
                                n_credits++;
                            end
                            m_pending = PD_IDLE;
                            m_status  = STAT_OK;
                        end
                    end
                end
                MODE_INSERT: begin
                    m_inserted = 1'b1;
                    m_status   = STAT_OK;
                end
                MODE_EJECT: begin
                    m_inserted = 1'b0;
                    m_status   = STAT_NOCARD;
                end
                default: ;
            endcase
            r.status_code   = m_status;
            r.card_present  = m_inserted;
            r.card_balance  = m_balance;
            r.pending_state = m_pending;
            return r;
        endfunction

        function void take_item(t_in_item it);
            awaited_replies.push_back(mirror_item(it));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at reply %0d, %s: got %h, expected %h",
                     n_checked, what, got, want);
            n_errors++;
        endtask

        task check_reply(t_out_item got);
            t_out_item want;
            if (awaited_replies.size() == 0) begin
                report("reply with nothing outstanding", 32'(got), 32'h0);
            end else begin
                want = awaited_replies.pop_front();
                if (got.read_data !== want.read_data)
                    report("read_data", got.read_data, want.read_data);
                if (got.dma_byte !== want.dma_byte)
                    report("dma_byte", 32'(got.dma_byte), 32'(want.dma_byte));
                if (got.status_code !== want.status_code)
                    report("status_code", 32'(got.status_code), 32'(want.status_code));
                if (got.card_present !== want.card_present)
                    report("card_present", 32'(got.card_present), 32'(want.card_present));
                if (got.card_balance !== want.card_balance)
                    report("card_balance", got.card_balance, want.card_balance);
                if (got.pending_state !== want.pending_state)
                    report("pending_state", 32'(got.pending_state),
                           32'(want.pending_state));
            end
            n_checked++;
        endtask
    endclass

    // generous bound: fill pass plus every item at its slowest, many times over
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    reply_scoreboard sb = new();

    // idle percentages, set per phase by the main sequence
    int snd_idle_pct;
    int rcv_idle_pct;
    int items_sent;
    int cycle_count;
    // long receiver hold-off, requested once by the main sequence
    bit hold_request;
    bit hold_served;

    card_reader_command_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // monitor: every handshake is sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // note the input first; the reply leaving now belongs to an older item
            if (i_in_valid && !o_in_stall) sb.take_item(i_in_data);
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
            if (o_out_valid && !i_out_stall) sb.check_reply(o_out_data);
        end
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, sb.awaited_replies.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall per cycle, plus one long hold-off that backs
    // the engine up until it stalls its input
    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        hold_served = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    function automatic t_in_item mk(logic [2:0] mode, logic [1:0] sel, logic [31:0] wv,
                                    logic [11:0] beat, logic [12:0] size, logic last);
        t_in_item it;
        it.mode            = mode;
        it.register_select = sel;
        it.write_value     = wv;
        it.beat_index      = beat;
        it.transfer_size   = size;
        it.last_beat       = last;
        return it;
    endfunction

    // offer one transaction, idling first at random; returns at the accepting edge
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic write_config(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering and let every owed reply come back
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // extremes of the fields and each special case, in a state-aware order
    task automatic run_directed;
        send_item(mk(MODE_REG_READ, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd0, 13'd1, 1'b1));  // idle beat
        // device id, full transfer then a short one
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_IDENT, 24'h0}, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd4, 13'd8, 1'b0));
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd7, 13'd8, 1'b1));
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_IDENT, 24'hFF_FFFF}, 12'd0, 13'd0,
                     1'b0));
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd5, 13'd7, 1'b1));
        // card read with no card
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_READ, 24'h0}, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd0, 13'd1, 1'b1));
        // card read with the offset at its top, wrapping around the card
        send_item(mk(MODE_INSERT, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_READ, 24'hFF_FFFF}, 12'd0, 13'd0,
                     1'b0));
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd1, 13'd0, 1'b1));  // zero size
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd1, 13'd4096, 1'b0));
        send_item(mk(MODE_DMA_READ, SEL_STATUS, 32'h0, 12'd4095, 13'd4096, 1'b1));
        // block prepare: nonzero status write ignored, zero-size write ignored
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_PREP, 24'h0}, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_WRITE, SEL_STATUS, 32'hFFFF_FFFF, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_DMA_WRITE, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_DMA_WRITE, SEL_STATUS, 32'h0, 12'd0, 13'd4096, 1'b0));
        // commit takes the last credit
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_COMMIT, 24'h0}, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_DMA_WRITE, SEL_STATUS, 32'h0, 12'd0, 13'd1, 1'b0));
        send_item(mk(MODE_DMA_WRITE, SEL_STATUS, 32'h0, 12'd0, 13'd1, 1'b0));  // idle write
        // status command, unknown opcodes, other register, status clear
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_STAT, 24'h0}, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, 32'h3C00_0000, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, 32'h4B12_3456, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_WRITE, SEL_COMMAND, 32'h78FF_FFFF, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_WRITE, SEL_OTHER, {OPC_PREP, 24'h0}, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_READ, SEL_OTHER, 32'h0, 12'd0, 13'd0, 1'b0));
        send_item(mk(MODE_REG_WRITE, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
        // eject, then the unused mode codes
        send_item(mk(MODE_EJECT, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
        send_item(mk(3'd6, SEL_COMMAND, {OPC_PREP, 24'h0}, 12'd0, 13'd1, 1'b1));
        send_item(mk(3'd7, SEL_COMMAND, {OPC_COMMIT, 24'h0}, 12'd0, 13'd1, 1'b1));
    endtask

    // mostly well-formed command/transfer sequences with random content,
    // the rest broken sequences and raw noise
    task automatic run_random(input int n_items, input bit with_hold);
        int          first;
        int          pick;
        int          n;
        int          base;
        logic [23:0] off;
        logic [12:0] size;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if (with_hold && items_sent - first > 40) hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // card read: offsets biased to the image header and the wrap points
                if (!sb.m_inserted && $urandom_range(0, 9) < 7)
                    send_item(mk(MODE_INSERT, 2'($urandom_range(0, 2)), $urandom, 12'd0,
                                 13'd0, 1'b0));
                case ($urandom_range(0, 4))
                    0: off = 24'($urandom_range(0, 15));
                    1: off = 24'($urandom_range(500, 511));
                    2: off = 24'hFF_FFFF - 24'($urandom_range(0, 15));
                    default: off = 24'($urandom);
                endcase
                send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_READ, off}, 12'd0, 13'd0,
                             1'b0));
                n    = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095 - n) : 0;
                size = ($urandom_range(0, 5) == 0) ? 13'($urandom_range(n, 4096)) : 13'(n);
                for (int i = 0; i < n; i++) begin
                    send_item(mk(MODE_DMA_READ, 2'($urandom_range(0, 2)), $urandom,
                                 12'(base + i), size,
                                 (i == n - 1) && ($urandom_range(0, 9) != 0)));
                end
            end else if (pick < 50) begin
                // device id read, sometimes with a short transfer size
                send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_IDENT, 24'($urandom)}, 12'd0,
                             13'd0, 1'b0));
                size = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 12)) : 13'd8;
                for (int i = 0; i < int'(size); i++) begin
                    send_item(mk(MODE_DMA_READ, 2'($urandom_range(0, 2)), $urandom,
                                 12'(i), size,
                                 (i == int'(size) - 1) && ($urandom_range(0, 9) != 0)));
                end
            end else if (pick < 65) begin
                // block prepare or commit, then the dma write
                case ($urandom_range(0, 5))
                    0: send_item(mk(MODE_INSERT, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
                    1: send_item(mk(MODE_EJECT, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
                    default: ;
                endcase
                send_item(mk(MODE_REG_WRITE, SEL_COMMAND,
                             {($urandom_range(0, 1) != 0) ? OPC_COMMIT : OPC_PREP,
                              24'($urandom)}, 12'd0, 13'd0, 1'b0));
                if ($urandom_range(0, 4) == 0)
                    send_item(mk(MODE_REG_READ, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
                if ($urandom_range(0, 9) == 0)
                    send_item(mk(MODE_DMA_WRITE, SEL_STATUS, $urandom, 12'($urandom),
                                 13'd0, 1'b0));
                send_item(mk(MODE_DMA_WRITE, 2'($urandom_range(0, 2)), $urandom,
                             12'($urandom), 13'($urandom_range(1, 4096)), 1'($urandom)));
            end else if (pick < 75) begin
                case ($urandom_range(0, 4))
                    0: send_item(mk(MODE_REG_READ, SEL_STATUS, $urandom, 12'd0, 13'd0, 1'b0));
                    1: send_item(mk(MODE_REG_WRITE, SEL_STATUS, 32'h0, 12'd0, 13'd0, 1'b0));
                    2: send_item(mk(MODE_REG_WRITE, SEL_STATUS, $urandom, 12'd0, 13'd0, 1'b0));
                    3: send_item(mk(MODE_REG_WRITE, SEL_COMMAND, {OPC_STAT, 24'($urandom)},
                                    12'd0, 13'd0, 1'b0));
                    default: send_item(mk(MODE_REG_WRITE, SEL_COMMAND, $urandom, 12'd0,
                                          13'd0, 1'b0));
                endcase
            end else if (pick < 83) begin
                send_item(mk(($urandom_range(0, 1) != 0) ? MODE_INSERT : MODE_EJECT,
                             2'($urandom_range(0, 2)), $urandom, 12'($urandom),
                             13'($urandom_range(0, 4096)), 1'($urandom)));
            end else begin
                send_item(mk(3'($urandom_range(0, 7)), 2'($urandom_range(0, 2)), $urandom,
                             12'($urandom), 13'($urandom_range(0, 4096)), 1'($urandom)));
            end
        end
    endtask

    initial begin : main
        // every input known from time zero
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_DEVICE_IDENT;
        i_cfg_data   = 32'h0;
        snd_idle_pct = 11;
        rcv_idle_pct = 79;
        items_sent   = 0;
        hold_request = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // let the card image fill pass finish before touching the balance
        repeat (2) @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);

        // directed part: one credit, so the commit empties the card
        write_config(CFG_DEVICE_IDENT, 32'hA1B2_C3D4);
        write_config(CFG_INITIAL_BALANCE, 32'h0000_0001);
        run_directed();
        drain();

        // sender mostly busy, receiver mostly stalled; all-zero registers
        write_config(CFG_DEVICE_IDENT, 32'h0);
        write_config(CFG_INITIAL_BALANCE, 32'h0);
        run_random(180, 1'b0);
        drain();

        // the other way round; all-ones registers
        snd_idle_pct = 79;
        rcv_idle_pct = 11;
        write_config(CFG_DEVICE_IDENT, 32'hFFFF_FFFF);
        write_config(CFG_INITIAL_BALANCE, 32'hFFFF_FFFF);
        run_random(180, 1'b0);
        drain();

        // back to back, with one long receiver hold-off to back the engine up
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_config(CFG_DEVICE_IDENT, $urandom);
        write_config(CFG_INITIAL_BALANCE, 32'd5);
        run_random(190, 1'b1);
        drain();
        repeat (10) @(posedge i_clk);

        $display("%0d transactions sent, %0d replies checked, %0d card bytes read,",
                 items_sent, sb.n_checked, sb.n_card_bytes);
        $display("%0d credits taken over four register settings, %0d mismatches",
                 sb.n_credits, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/crce_pkg.sv
hdl/crce_card_store.sv
hdl/card_reader_command_engine_top.sv
tb/tb_top.sv
